/* rtl/ps2_mouse_packet_cursor_macros.svh */
// Assertion macros used by the checker file of the mouse cursor block.
`ifndef PS2_MOUSE_PACKET_CURSOR_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_MACROS_SVH

// Check that holds at every edge, reset included.
`define PS2MC_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Check that is switched off while reset is high.
`define PS2MC_CHECK_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

/* rtl/ps2mc_pkg.sv */
// Shared constants, types and the clamp function of the mouse cursor block.
`timescale 1ns / 1ps

package ps2mc_pkg;

  // Field widths.
  localparam int BYTE_W     = 8;
  localparam int LIMIT_W    = 12;
  localparam int CURSOR_W   = 12;
  localparam int CFG_IDX_W  = 4;
  localparam int COORD_BITS = 12;

  // Signed width that holds a position plus or minus one movement byte.
  localparam int SUM_W = ((COORD_BITS > LIMIT_W) ? COORD_BITS : LIMIT_W) + 2;

  localparam logic [SUM_W-1:0]      COORD_MAX     = SUM_W'((1 << COORD_BITS) - 1);
  localparam logic [COORD_BITS-1:0] POS_RESET     = COORD_BITS'(100);
  localparam logic [LIMIT_W-1:0]    X_LIMIT_RESET = LIMIT_W'(1024);
  localparam logic [LIMIT_W-1:0]    Y_LIMIT_RESET = LIMIT_W'(768);

  // Bit of the header byte that is always set in a valid packet.
  localparam int HDR_SYNC_BIT = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT = CFG_IDX_W'(1);

  // Position of the next byte within a packet.
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DX     = 2'd1,
    PH_DY     = 2'd2
  } phase_t;

  // Clamp ceilings handed from the register file to the decoder.
  typedef struct packed {
    logic [LIMIT_W-1:0] x_limit;
    logic [LIMIT_W-1:0] y_limit;
  } limits_t;

  // One result item.
  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_x;
    logic [CURSOR_W-1:0] cursor_y;
  } cursor_res_t;

  // Clamp a signed sum to zero and to the smaller of the limit and the coordinate range.
  function automatic logic [COORD_BITS-1:0] clamp_coord(input logic signed [SUM_W-1:0] v,
                                                         input logic [LIMIT_W-1:0] limit);
    logic [SUM_W-1:0] lim_ext;
    logic [SUM_W-1:0] ceil_v;
    logic [SUM_W-1:0] res;
    lim_ext = SUM_W'(limit);
    ceil_v  = (lim_ext < COORD_MAX) ? lim_ext : COORD_MAX;
    if (v[SUM_W-1]) begin
      res = '0;
    end else if ($unsigned(v) > ceil_v) begin
      res = ceil_v;
    end else begin
      res = $unsigned(v);
    end
    return COORD_BITS'(res);
  endfunction

endpackage

/* rtl/ps2mc_channels.sv */
// Handshake channel interfaces of the mouse cursor block.
`timescale 1ns / 1ps

// Byte stream from the mouse data port.
interface ps2mc_byte_if
  import ps2mc_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Cursor position results.
interface ps2mc_cursor_if
  import ps2mc_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [CURSOR_W-1:0] cursor_x;
  logic [CURSOR_W-1:0] cursor_y;

  modport source (output valid, output cursor_x, output cursor_y, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, output ready);
endinterface

// Configuration register writes.
interface ps2mc_cfg_if
  import ps2mc_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [LIMIT_W-1:0]   wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

/* rtl/ps2mc_cfg_regs.sv */
// Configuration registers holding the cursor clamp limits.
`timescale 1ns / 1ps

module ps2mc_cfg_regs
  import ps2mc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [LIMIT_W-1:0]   wr_data,
  output limits_t              limits
);

  limits_t regs;

  // Writes are always taken; unknown indexes are dropped.
  assign wr_ready = 1'b1;
  assign limits   = regs;

  // Register file update.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.x_limit <= X_LIMIT_RESET;
      regs.y_limit <= Y_LIMIT_RESET;
    end else if (wr_valid) begin
      unique case (wr_index)
        REG_X_LIMIT: regs.x_limit <= wr_data;
        REG_Y_LIMIT: regs.y_limit <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/ps2mc_in_reg.sv */
// Input register that captures one received byte per transfer.
`timescale 1ns / 1ps

module ps2mc_in_reg
  import ps2mc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              held_valid,
  output logic [BYTE_W-1:0] held_byte,
  input  logic              take
);

  logic              vld;
  logic [BYTE_W-1:0] data;

  // A new byte enters when the register is empty or is being drained.
  assign in_ready   = !vld || take;
  assign held_valid = vld;
  assign held_byte  = data;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  // Byte storage.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_byte;
    end
  end

endmodule

/* rtl/ps2mc_decode.sv */
// Framing, cursor update, clamping: one byte per cycle unless stalled.
`timescale 1ns / 1ps

module ps2mc_decode
  import ps2mc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  input  logic [BYTE_W-1:0] byte_data,
  output logic              take,
  input  limits_t           limits,
  output logic              res_valid,
  input  logic              res_space,
  output cursor_res_t       res
);

  phase_t                  phase;
  phase_t                  phase_next;
  logic [BYTE_W-1:0]       dx_byte;
  logic [COORD_BITS-1:0]   pos_x;
  logic [COORD_BITS-1:0]   pos_y;
  logic [COORD_BITS-1:0]   pos_x_next;
  logic [COORD_BITS-1:0]   pos_y_next;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic                    last_byte;

  // Only the last byte of a packet needs room in the output register.
  assign last_byte = (phase == PH_DY);
  assign take      = byte_valid && (!last_byte || res_space);
  assign res_valid = take && last_byte;

  // New position: X gains dx, Y loses dy since screen Y grows downward.
  always_comb begin
    sum_x      = $signed(SUM_W'(pos_x)) + SUM_W'($signed(dx_byte));
    sum_y      = $signed(SUM_W'(pos_y)) - SUM_W'($signed(byte_data));
    pos_x_next = clamp_coord(sum_x, limits.x_limit);
    pos_y_next = clamp_coord(sum_y, limits.y_limit);
  end

  assign res.cursor_x = CURSOR_W'(pos_x_next);
  assign res.cursor_y = CURSOR_W'(pos_y_next);

  // Phase sequencing; a header without the sync bit is dropped.
  always_comb begin
    case (phase)
      PH_DX:   phase_next = PH_DY;
      PH_DY:   phase_next = PH_HEADER;
      default: phase_next = byte_data[HDR_SYNC_BIT] ? PH_DX : PH_HEADER;
    endcase
  end

  // Packet state and cursor position.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HEADER;
      dx_byte <= '0;
      pos_x   <= POS_RESET;
      pos_y   <= POS_RESET;
    end else if (take) begin
      phase <= phase_next;
      if (phase == PH_DX) begin
        dx_byte <= byte_data;
      end
      if (last_byte) begin
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
      end
    end
  end

endmodule

/* rtl/ps2mc_out_reg.sv */
// Output register that holds one cursor result until it is taken.
`timescale 1ns / 1ps

module ps2mc_out_reg
  import ps2mc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        res_valid,
  output logic        res_space,
  input  cursor_res_t res,
  output logic        out_valid,
  input  logic        out_ready,
  output cursor_res_t out_data
);

  logic        vld;
  cursor_res_t data;

  // Room for a new result when empty or when the held one leaves now.
  assign res_space = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = data;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (res_space) begin
      vld <= res_valid;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (res_space && res_valid) begin
      data <= res;
    end
  end

endmodule

/* rtl/ps2_mouse_packet_cursor.sv */
// PS/2 mouse packet decoder: turns 3-byte mouse packets into a clamped cursor position.
// Bytes arrive on byte_in, one byte per transfer, and a header byte with bit 3 clear
// is dropped so the stream can regain sync. On the third byte of each packet the cursor
// moves by dx and by minus dy, each coordinate is clamped to 0 and to its limit register
// (x_limit at index 0, y_limit at index 1, both on cfg_wr; the user must write them
// only while the block is idle, which the block does not enforce), and one result is
// sent on cursor_out. The cursor starts at (100, 100). An input register feeds a short
// add-and-clamp path into an output register, so a new byte is taken on every cycle
// unless a held result stalls it. A result enters the output register when its last
// byte leaves the input register. A held result stalls the last byte of the next packet
// in the input register, and the byte stream waits behind it until the result is taken.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor
  import ps2mc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  ps2mc_byte_if.sink            byte_in,
  ps2mc_cursor_if.source        cursor_out,
  ps2mc_cfg_if.sink             cfg_wr
);

  limits_t           limits;
  logic              held_valid;
  logic [BYTE_W-1:0] held_byte;
  logic              take;
  logic              res_valid;
  logic              res_space;
  cursor_res_t       res;
  cursor_res_t       out_data;

  // Clamp limit registers.
  ps2mc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg_wr.valid),
    .wr_ready (cfg_wr.ready),
    .wr_index (cfg_wr.reg_index),
    .wr_data  (cfg_wr.wdata),
    .limits   (limits)
  );

  // Input byte register.
  ps2mc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (byte_in.valid),
    .in_ready   (byte_in.ready),
    .in_byte    (byte_in.rx_byte),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .take       (take)
  );

  // Packet framing and cursor arithmetic.
  ps2mc_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (held_valid),
    .byte_data  (held_byte),
    .take       (take),
    .limits     (limits),
    .res_valid  (res_valid),
    .res_space  (res_space),
    .res        (res)
  );

  // Result register.
  ps2mc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_space (res_space),
    .res       (res),
    .out_valid (cursor_out.valid),
    .out_ready (cursor_out.ready),
    .out_data  (out_data)
  );

  assign cursor_out.cursor_x = out_data.cursor_x;
  assign cursor_out.cursor_y = out_data.cursor_y;

endmodule

/* rtl/ps2mc_checker.sv */
// Port-level checks for the mouse cursor block and their binding.
`timescale 1ns / 1ps
`include "ps2_mouse_packet_cursor_macros.svh"

module ps2mc_checker
  import ps2mc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                byte_ready,
  input logic                cursor_valid,
  input logic                cursor_ready,
  input logic [CURSOR_W-1:0] cursor_x,
  input logic [CURSOR_W-1:0] cursor_y
);

  // Reset empties the result register.
  `PS2MC_CHECK(a_reset_no_result, rst |=> !cursor_valid, "result valid right after reset")

  // Reset empties the input register, so a byte can be taken at once.
  `PS2MC_CHECK(a_reset_ready, rst |=> byte_ready, "byte channel not ready after reset")

  // A stalled result stays offered.
  `PS2MC_CHECK_RUN(a_result_held, (cursor_valid && !cursor_ready) |=> cursor_valid,
                   "result withdrawn while stalled")

  // A stalled result keeps its coordinates.
  `PS2MC_CHECK_RUN(a_result_stable,
                   (cursor_valid && !cursor_ready) |=> ($stable(cursor_x) && $stable(cursor_y)),
                   "result changed while stalled")

endmodule

bind ps2_mouse_packet_cursor ps2mc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_ready   (byte_in.ready),
  .cursor_valid (cursor_out.valid),
  .cursor_ready (cursor_out.ready),
  .cursor_x     (cursor_out.cursor_x),
  .cursor_y     (cursor_out.cursor_y)
);
